// ----- hw/rtl/integer_to_radix_ascii_unit_assert.svh -----
// assertion macros shared by the integer to radix ascii rtl
`ifndef INTEGER_TO_RADIX_ASCII_UNIT_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define ITR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("itr assertion failed");

// condition must hold in the cycle after the trigger
`define ITR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("itr assertion failed");

`endif

// ----- hw/rtl/itr_pkg.sv -----
// shared types, constants and helpers for the integer to radix ascii unit
`default_nettype none

package itr_pkg;

    // operand and counter widths
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = ADDR_W - 2;

    // register map
    localparam logic [REG_IDX_W-1:0] REG_RADIX = REG_IDX_W'(0);

    // radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_PUT
    } itr_state_t;

    // divider request and response
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_W-1:0]    divisor;
    } itr_div_req_t;

    typedef struct packed {
        logic                  done;
        logic                  busy;
        logic [VALUE_BITS-1:0] quotient;
        logic [RADIX_W-1:0]    remainder;
    } itr_div_rsp_t;

    // digit value to ascii, 0-9 then A-Z
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < RADIX_DEC) begin
            return CHAR_ZERO + d_ext;
        end else begin
            return CHAR_UPPER_A + d_ext - CHAR_W'(RADIX_DEC);
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/itr_divider.sv -----
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module itr_divider (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire itr_pkg::itr_div_req_t req,
    output itr_pkg::itr_div_rsp_t      rsp
);
    import itr_pkg::*;

    localparam int STEP_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    dvs_reg, dvs_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    // one shift-subtract step
    logic [RADIX_W:0] trial;
    logic [RADIX_W:0] diff;
    logic             fits;

    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            q_next    = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next    = {q_reg[VALUE_BITS-2:0], fits};
            rem_next  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = rem_reg;

`include "integer_to_radix_ascii_unit_assert.svh"

    // a new division never starts over one in progress
    `ITR_ASSERT_SAME(a_start_when_free, aclk, aresetn, req.start, !busy_reg && !done_reg)
    // the final step always raises done
    `ITR_ASSERT_NEXT(a_done_after_last, aclk, aresetn,
        busy_reg && !req.start && (step_reg == STEP_W'(VALUE_BITS - 1)), done_reg && !busy_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_radix_ascii_unit.sv -----
// integer to ascii text converter in a configurable radix
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------
//  s_        | in        | s_valid / s_ready  | s_value (32-bit, signed only in radix 10)
//  m_        | out       | m_valid / m_ready  | m_char_code, m_last_char
//  apb       | in        | psel / penable     | paddr, pwdata, prdata (radix)
//
// each digit costs one full pass of the bit-serial divider (one quotient bit per cycle),
// and the first character appears only after every digit has been divided out;
// characters then leave one at a time, each through a registered digit store read and a put state.
// a negative decimal value first sends a minus sign from its own sign state.
// reset is synchronous and active low; the radix register resets to ten.
// a stalled m_ready holds the output word and pauses the read-out; s_ready is high only
// while no conversion is in progress.
`default_nettype none

module integer_to_radix_ascii_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input word
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [itr_pkg::VALUE_BITS-1:0] s_value,
    // result word
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [itr_pkg::CHAR_W-1:0]                 m_char_code,
    output logic                                       m_last_char,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [itr_pkg::ADDR_W-1:0]            paddr,
    input  wire logic [itr_pkg::DATA_W-1:0]            pwdata,
    output logic [itr_pkg::DATA_W-1:0]                 prdata,
    output logic                                       pready
);
    import itr_pkg::*;

    // configuration register
    logic [RADIX_W-1:0] radix_reg;
    logic               cfg_write;
    logic               radix_sel;

    assign pready    = 1'b1;
    assign radix_sel = (paddr[ADDR_W-1:2] == REG_RADIX);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = radix_sel ? DATA_W'(radix_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_write && radix_sel) begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    // radix clamped to the supported range
    logic [RADIX_W-1:0] radix_eff;
    always_comb begin
        priority if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    // sequencer state and datapath registers
    itr_state_t            state_reg, state_next;
    logic [RADIX_W-1:0]    base_reg, base_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  start_reg, start_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     m_char_code_reg, m_char_code_next;
    logic                  m_last_reg, m_last_next;

    // digit store
    logic [RADIX_W-1:0] store_mem [VALUE_BITS];
    logic [RADIX_W-1:0] rd_data_reg;
    logic               wr_en;

    // divider link
    itr_div_req_t div_req;
    itr_div_rsp_t div_rsp;

    assign div_req.start    = start_reg;
    assign div_req.dividend = quot_reg;
    assign div_req.divisor  = base_reg;

    itr_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // input decode
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_bits;
    logic                  out_free;

    assign in_bits  = s_value;
    assign in_neg   = (radix_eff == RADIX_DEC) && s_value[VALUE_BITS-1];
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // next state and datapath control
    always_comb begin
        state_next       = state_reg;
        base_next        = base_reg;
        neg_next         = neg_reg;
        quot_next        = quot_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        start_next       = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_char_code_next = m_char_code_reg;
        m_last_next      = m_last_reg;
        wr_en            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    base_next  = radix_eff;
                    neg_next   = in_neg;
                    quot_next  = in_neg ? (~in_bits + VALUE_BITS'(1)) : in_bits;
                    cnt_next   = '0;
                    start_next = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    wr_en     = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    quot_next = div_rsp.quotient;
                    if ((div_rsp.quotient == '0) || (cnt_reg == CNT_W'(VALUE_BITS - 1))) begin
                        idx_next   = cnt_reg[IDX_W-1:0];
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                    end else begin
                        start_next = 1'b1;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_char_code_next = CHAR_MINUS;
                    m_last_next      = 1'b0;
                    state_next       = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_char_code_next = digit_char(rd_data_reg);
                    m_last_next      = (idx_reg == '0);
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            quot_reg    <= '0;
            neg_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            quot_reg    <= quot_next;
            neg_reg     <= neg_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        base_reg        <= base_next;
        idx_reg         <= idx_next;
        m_char_code_reg <= m_char_code_next;
        m_last_reg      <= m_last_next;
    end

    // digit store write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[cnt_reg[IDX_W-1:0]] <= div_rsp.remainder;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_code_reg;
    assign m_last_char = m_last_reg;

`include "integer_to_radix_ascii_unit_assert.svh"

    // divider results arrive only while dividing
    `ITR_ASSERT_SAME(a_done_in_divide, aclk, aresetn, div_rsp.done, state_reg == ST_DIVIDE)
    // the digit store never overflows
    `ITR_ASSERT_SAME(a_store_in_range, aclk, aresetn, wr_en, cnt_reg < CNT_W'(VALUE_BITS))
    // the minus sign is never the final character
    `ITR_ASSERT_SAME(a_sign_not_last, aclk, aresetn,
        m_valid_reg && (m_char_code_reg == CHAR_MINUS), !m_last_reg)

endmodule

`default_nettype wire

// ----- test/integer_to_radix_ascii_unit_checker.sv -----
// checker for the integer to radix ascii unit: tracks the radix, predicts the text, compares words
`default_nettype none

module integer_to_radix_ascii_unit_checker (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    input  wire logic                                  s_ready,
    input  wire logic signed [itr_pkg::VALUE_BITS-1:0] s_value,
    input  wire logic                                  m_valid,
    input  wire logic                                  m_ready,
    input  wire logic [itr_pkg::CHAR_W-1:0]            m_char_code,
    input  wire logic                                  m_last_char,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic                                  pready,
    input  wire logic [itr_pkg::ADDR_W-1:0]            paddr,
    input  wire logic [itr_pkg::DATA_W-1:0]            pwdata,
    output int                                         fail_count,
    output int                                         pending_chars
);
    import itr_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic [RADIX_W-1:0] radix_setting;
    text_char_t         expected_text[$];

    // convert one value to its characters, most significant digit first
    task automatic predict_text(input logic [VALUE_BITS-1:0] v);
        logic [RADIX_W-1:0]    base;
        logic                  negative;
        logic [VALUE_BITS-1:0] quotient;
        logic [RADIX_W-1:0]    digit_buf[VALUE_BITS];
        logic [CHAR_W-1:0]     code;
        int                    n;
        // out-of-range radix settings clamp to the nearest legal base
        if (radix_setting < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix_setting > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = radix_setting;
        end
        // only decimal is signed, the most negative value wraps to its own magnitude
        negative = (base == RADIX_DEC) && v[VALUE_BITS-1];
        quotient = negative ? -v : v;
        n = 0;
        // remainders come out least significant first
        do begin
            digit_buf[n] = RADIX_W'(quotient % VALUE_BITS'(base));
            quotient     = quotient / VALUE_BITS'(base);
            n++;
        end while (quotient != '0 && n < VALUE_BITS);
        if (negative) begin
            expected_text.push_back('{code: CHAR_MINUS, last: 1'b0});
        end
        for (int k = n - 1; k >= 0; k--) begin
            if (digit_buf[k] < RADIX_DEC) begin
                code = CHAR_ZERO + CHAR_W'(digit_buf[k]);
            end else begin
                code = CHAR_UPPER_A + CHAR_W'(digit_buf[k] - RADIX_DEC);
            end
            expected_text.push_back('{code: code, last: (k == 0)});
        end
    endtask

    // follow register writes, predict on accepted values, check accepted words
    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            radix_setting = RADIX_RESET;
            expected_text.delete();
            fail_count    = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == {REG_RADIX, 2'b00}) begin
                radix_setting = pwdata[RADIX_W-1:0];
            end
            if (s_valid && s_ready) begin
                predict_text(s_value);
            end
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected word: char 0x%02h last %0b",
                                 m_char_code, m_last_char);
                    end
                    fail_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_char_code !== want.code || m_last_char !== want.last) begin
                        if (fail_count < 10) begin
                            $display("word mismatch: expected char 0x%02h last %0b, got 0x%02h last %0b",
                                     want.code, want.last, m_char_code, m_last_char);
                        end
                        fail_count++;
                    end
                end
            end
        end
        pending_chars = expected_text.size();
    end

endmodule

`default_nettype wire

// ----- test/integer_to_radix_ascii_unit_tb.sv -----
// testbench top for the integer to radix ascii unit: stimulus, idling phases and verdict
`default_nettype none

module integer_to_radix_ascii_unit_tb;
    import itr_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int ITEMS_PER_PHASE = 12;
    localparam int RANDOM_PHASES   = 8;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [VALUE_BITS-1:0] s_value = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [CHAR_W-1:0]            m_char_code;
    logic                         m_last_char;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [ADDR_W-1:0]            paddr = '0;
    logic [DATA_W-1:0]            pwdata = '0;
    logic [DATA_W-1:0]            prdata;
    logic                         pready;

    int check_fails;
    int pending_chars;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    integer_to_radix_ascii_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    integer_to_radix_ascii_unit_checker text_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_last_char   (m_last_char),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (check_fails),
        .pending_chars (pending_chars)
    );

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one value word, called and returning at a falling edge
    task automatic send_value(input logic [VALUE_BITS-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    // let the text drain, then write the radix through a setup and an access cycle
    task automatic set_radix(input logic [RADIX_W-1:0] r);
        s_valid <= 1'b0;
        while (pending_chars != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_RADIX, 2'b00};
        pwdata  <= {(DATA_W - RADIX_W)'($urandom), r};
        @(negedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random value biased toward digit-count and sign corners
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] one;
        one = VALUE_BITS'(1);
        case ($urandom_range(9))
            4:       return VALUE_BITS'($urandom_range(40));
            5:       return -VALUE_BITS'($urandom_range(40, 1));
            6: begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return one;
                    2:       return '1;
                    3:       return {1'b0, {(VALUE_BITS-1){1'b1}}};
                    default: return {1'b1, {(VALUE_BITS-1){1'b0}}};
                endcase
            end
            7:       return one << $urandom_range(VALUE_BITS - 1);
            8:       return (one << $urandom_range(VALUE_BITS - 1)) - one;
            9:       return VALUE_BITS'($urandom) >> $urandom_range(VALUE_BITS - 1);
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // stimulus: directed corners per radix, then random phases
    initial begin
        logic [RADIX_W-1:0] phase_radix;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // decimal: zero, sign handling, ten-digit and most negative values
        set_radix(RADIX_DEC);
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1_000_000_000);

        // binary: longest strings, negative patterns read as unsigned
        set_radix(RADIX_MIN);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);

        // base 36: top digit and rollover
        set_radix(RADIX_MAX);
        send_value(32'd35);
        send_value(32'd36);
        send_value(32'hFFFF_FFFF);

        set_radix(RADIX_W'(16));
        send_value(32'hDEAD_BEEF);
        send_value(-32'sd1);

        // radix settings outside 2..36 clamp
        set_radix(RADIX_W'(0));
        send_value(32'd5);
        set_radix(RADIX_W'(1));
        send_value(32'd6);
        set_radix(RADIX_W'(37));
        send_value(32'd35);
        set_radix(RADIX_W'(63));
        send_value(32'hFFFF_FFFF);

        // random phases cycling through the idling modes
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0, 5:    phase_radix = RADIX_DEC;
                1:       phase_radix = RADIX_MIN;
                2:       phase_radix = RADIX_MAX;
                3:       phase_radix = RADIX_W'(16);
                4:       phase_radix = RADIX_W'($urandom_range(63));
                6:       phase_radix = RADIX_W'(7);
                default: phase_radix = RADIX_W'($urandom_range(36, 2));
            endcase
            set_radix(phase_radix);
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                end
                default: begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_value(random_value());
        end

        // drain and settle
        s_valid <= 1'b0;
        while (pending_chars != 0) begin
            @(negedge aclk);
        end
        repeat (40) @(negedge aclk);
        if (check_fails == 0 && pending_chars == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/itr_pkg.sv
hw/rtl/itr_divider.sv
hw/rtl/integer_to_radix_ascii_unit.sv
test/integer_to_radix_ascii_unit_checker.sv
test/integer_to_radix_ascii_unit_tb.sv
